// File: hdl/rgbyuv_pkg.sv
package rgbyuv_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam int CHAN_W = 8;
    localparam int SUM_W  = 16;

    // BT.601 integer coefficients; negative terms are kept as magnitudes
    // and subtracted
    localparam logic [CHAN_W-1:0] Y_R  = 8'd66;
    localparam logic [CHAN_W-1:0] Y_G  = 8'd129;
    localparam logic [CHAN_W-1:0] Y_B  = 8'd25;
    localparam logic [CHAN_W-1:0] CB_R = 8'd38;
    localparam logic [CHAN_W-1:0] CB_G = 8'd74;
    localparam logic [CHAN_W-1:0] CB_B = 8'd112;
    localparam logic [CHAN_W-1:0] CR_R = 8'd112;
    localparam logic [CHAN_W-1:0] CR_G = 8'd94;
    localparam logic [CHAN_W-1:0] CR_B = 8'd18;

    localparam logic [SUM_W-1:0]  ROUND_HALF  = 16'd128;
    // rounding term plus 128 << 8, keeps the chroma sums non-negative
    localparam logic [SUM_W-1:0]  CHROMA_BIAS = 16'd32896;
    localparam logic [CHAN_W-1:0] LUMA_OFFSET = 8'd16;
    localparam logic [CHAN_W-1:0] CHROMA_NEUTRAL = 8'd128;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic chroma;   // second pixel of a pair on an even row
        logic last;     // last pixel of the frame
    } pixel_ctrl_t;

endpackage

// File: hdl/rgb_to_yuv420_converter.sv
// RGB to YCbCr 4:2:0 converter, integer BT.601 studio range. Pixels enter in
// raster order, one per clock while pixel_stall is low; each pixel leaves as one
// result through an input register, then a result register, so throughput is
// one pixel per cycle as long as result_stall stays low. Luma comes with every
// pixel; on even rows the second pixel of each horizontal pair also carries
// Cb/Cr of the pair average (chroma_valid high), otherwise Cb/Cr read 128.
// frame_last marks the last pixel of a frame. frame_width and frame_height
// are rounded down to even and clamped to 2..MAX_DIMENSION; write them only
// while the block is empty. The column/row position is updated as each pixel
// is accepted.
module rgb_to_yuv420_converter #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbyuv_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [7:0]                          luma,
    output logic                                chroma_valid,
    output logic [7:0]                          cb_value,
    output logic [7:0]                          cr_value,
    output logic                                frame_last
);

    rgbyuv_pkg::pixel_t      pixel_in;
    rgbyuv_pkg::pixel_t      held;
    rgbyuv_pkg::pixel_ctrl_t ctrl;
    rgbyuv_pkg::pixel_t      pix_s1_reg;
    rgbyuv_pkg::pixel_ctrl_t ctrl_s1_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [7:0]              luma_reg;
    logic [7:0]              cb_reg;
    logic [7:0]              cr_reg;
    logic                    chroma_reg;
    logic                    last_reg;
    logic [7:0]              luma_calc;
    logic [7:0]              cb_calc;
    logic [7:0]              cr_calc;
    logic                    accept;
    logic                    advance;

    assign pixel_in.red   = red;
    assign pixel_in.green = green;
    assign pixel_in.blue  = blue;

    assign advance     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign pixel_stall = s1_valid_reg && !advance;
    assign accept      = pixel_valid && !pixel_stall;

    rgbyuv_raster #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (pixel_in),
        .ctrl      (ctrl),
        .held      (held)
    );

    // held only changes when the next pair starts, which is the same edge the
    // second pixel of this pair leaves the input register
    rgbyuv_color u_color (
        .cur    (pix_s1_reg),
        .held   (held),
        .chroma (ctrl_s1_reg.chroma),
        .luma   (luma_calc),
        .cb     (cb_calc),
        .cr     (cr_calc)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_s1_reg  <= pixel_in;
            ctrl_s1_reg <= ctrl;
        end
        if (advance)
        begin
            luma_reg   <= luma_calc;
            cb_reg     <= cb_calc;
            cr_reg     <= cr_calc;
            chroma_reg <= ctrl_s1_reg.chroma;
            last_reg   <= ctrl_s1_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_valid = chroma_reg;
    assign cb_value     = cb_reg;
    assign cr_value     = cr_reg;
    assign frame_last   = last_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the input register");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && result_stall) |=>
            (s1_valid_reg && $stable(pix_s1_reg) && $stable(ctrl_s1_reg)))
        else $error("input register lost a pixel while the result was blocked");

    a_neutral_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !chroma_valid) |->
            (cb_value == rgbyuv_pkg::CHROMA_NEUTRAL &&
             cr_value == rgbyuv_pkg::CHROMA_NEUTRAL))
        else $error("chroma not neutral on a result without chroma");

endmodule

// File: hdl/rgbyuv_raster.sv
module rgbyuv_raster #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbyuv_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                accept,
    input  rgbyuv_pkg::pixel_t                  pixel,
    output rgbyuv_pkg::pixel_ctrl_t             ctrl,
    output rgbyuv_pkg::pixel_t                  held
);

    localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int SZ_W  = (DIM_W > rgbyuv_pkg::CFG_W) ? DIM_W + 1 : rgbyuv_pkg::CFG_W + 1;
    localparam logic [SZ_W-1:0] TOP_SIZE = SZ_W'(MAX_DIMENSION - (MAX_DIMENSION % 2));
    localparam logic [SZ_W-1:0] MIN_SIZE = SZ_W'(2);

    logic [rgbyuv_pkg::CFG_W-1:0] width_reg;
    logic [rgbyuv_pkg::CFG_W-1:0] height_reg;
    logic [CNT_W-1:0]             col_reg;
    logic [CNT_W-1:0]             col_next;
    logic [CNT_W-1:0]             row_reg;
    logic [CNT_W-1:0]             row_next;
    rgbyuv_pkg::pixel_t           held_reg;
    logic [CNT_W-1:0]             col_last;
    logic [CNT_W-1:0]             row_last;
    logic                         row_end;
    logic                         frame_end;

    function automatic logic [CNT_W-1:0] last_pos(input logic [rgbyuv_pkg::CFG_W-1:0] size);
        logic [SZ_W-1:0] v;
        v = SZ_W'(size) & ~SZ_W'(1);
        if (v < MIN_SIZE)
        begin
            v = MIN_SIZE;
        end
        if (v > TOP_SIZE)
        begin
            v = TOP_SIZE;
        end
        v = v - SZ_W'(1);
        return v[CNT_W-1:0];
    endfunction

    assign col_last  = last_pos(width_reg);
    assign row_last  = last_pos(height_reg);
    assign row_end   = col_reg >= col_last;
    assign frame_end = row_end && (row_reg >= row_last);

    assign ctrl.chroma = !row_reg[0] && col_reg[0];
    assign ctrl.last   = frame_end;
    assign held        = held_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            priority if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgbyuv_pkg::FRAME_WIDTH_RST;
            height_reg <= rgbyuv_pkg::FRAME_HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    rgbyuv_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    rgbyuv_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            // hold the first pixel of each pair on even rows
            if (accept && !row_reg[0] && !col_reg[0])
            begin
                held_reg <= pixel;
            end
        end
    end

endmodule

// File: hdl/rgbyuv_color.sv
module rgbyuv_color (
    input  rgbyuv_pkg::pixel_t                  cur,
    input  rgbyuv_pkg::pixel_t                  held,
    input  logic                                chroma,
    output logic [rgbyuv_pkg::CHAN_W-1:0]       luma,
    output logic [rgbyuv_pkg::CHAN_W-1:0]       cb,
    output logic [rgbyuv_pkg::CHAN_W-1:0]       cr
);

    localparam int W = rgbyuv_pkg::SUM_W;
    localparam int C = rgbyuv_pkg::CHAN_W;

    logic [C:0]   sum_r;
    logic [C:0]   sum_g;
    logic [C:0]   sum_b;
    logic [C-1:0] avg_r;
    logic [C-1:0] avg_g;
    logic [C-1:0] avg_b;
    logic [W-1:0] y_sum;
    logic [W-1:0] cb_sum;
    logic [W-1:0] cr_sum;

    assign sum_r = {1'b0, held.red}   + {1'b0, cur.red};
    assign sum_g = {1'b0, held.green} + {1'b0, cur.green};
    assign sum_b = {1'b0, held.blue}  + {1'b0, cur.blue};
    assign avg_r = sum_r[C:1];
    assign avg_g = sum_g[C:1];
    assign avg_b = sum_b[C:1];

    assign y_sum = W'(rgbyuv_pkg::Y_R) * W'(cur.red)
                 + W'(rgbyuv_pkg::Y_G) * W'(cur.green)
                 + W'(rgbyuv_pkg::Y_B) * W'(cur.blue)
                 + rgbyuv_pkg::ROUND_HALF;

    // bias keeps both sums in 4336..61456, so the top byte is the floor shift
    assign cb_sum = rgbyuv_pkg::CHROMA_BIAS
                  + W'(rgbyuv_pkg::CB_B) * W'(avg_b)
                  - W'(rgbyuv_pkg::CB_R) * W'(avg_r)
                  - W'(rgbyuv_pkg::CB_G) * W'(avg_g);

    assign cr_sum = rgbyuv_pkg::CHROMA_BIAS
                  + W'(rgbyuv_pkg::CR_R) * W'(avg_r)
                  - W'(rgbyuv_pkg::CR_G) * W'(avg_g)
                  - W'(rgbyuv_pkg::CR_B) * W'(avg_b);

    assign luma = y_sum[W-1:C] + rgbyuv_pkg::LUMA_OFFSET;
    assign cb   = chroma ? cb_sum[W-1:C] : rgbyuv_pkg::CHROMA_NEUTRAL;
    assign cr   = chroma ? cr_sum[W-1:C] : rgbyuv_pkg::CHROMA_NEUTRAL;

endmodule

// File: dv/yuv420_output_checker.sv
module yuv420_output_checker #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbyuv_pkg::CFG_W-1:0]       cfg_data,
    input  logic                               pixel_valid,
    input  logic                               pixel_stall,
    input  logic [7:0]                         red,
    input  logic [7:0]                         green,
    input  logic [7:0]                         blue,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  logic [7:0]                         luma,
    input  logic                               chroma_valid,
    input  logic [7:0]                         cb_value,
    input  logic [7:0]                         cr_value,
    input  logic                               frame_last,
    output int                                 mismatch_count,
    output int                                 pending_count,
    output int                                 results_checked,
    output int                                 frames_closed,
    output int                                 chroma_pairs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       last;
    } yuv_sample_t;

    yuv_sample_t                  expected_yuv [$];
    logic [rgbyuv_pkg::CFG_W-1:0] width_reg;
    logic [rgbyuv_pkg::CFG_W-1:0] height_reg;
    int unsigned                  column_pos;
    int unsigned                  row_pos;
    rgbyuv_pkg::pixel_t           pair_first;

    // round down to even, then clamp to 2..MAX_DIMENSION
    function automatic int unsigned usable_size(logic [rgbyuv_pkg::CFG_W-1:0] value);
        int unsigned v;
        int unsigned top;
        v = 32'({value[rgbyuv_pkg::CFG_W-1:1], 1'b0});
        top = MAX_DIMENSION & ~1;
        if (v < 2)
            v = 2;
        if (v > top)
            v = top;
        return v;
    endfunction

    // floor((sum + 128) / 256) + 128, biased so the shift never sees a negative
    function automatic logic [7:0] chroma_from(int sum);
        return 8'((sum + 128 + 32768) >> 8);
    endfunction

    function automatic yuv_sample_t convert_pixel(rgbyuv_pkg::pixel_t px);
        yuv_sample_t res;
        int unsigned w;
        int unsigned h;
        int          ra;
        int          ga;
        int          ba;
        logic        row_end;
        logic        frame_end;
        w = usable_size(width_reg);
        h = usable_size(height_reg);
        res.luma = 8'(((66 * int'(px.red) + 129 * int'(px.green)
                        + 25 * int'(px.blue) + 128) >> 8) + 16);
        res.chroma = 1'b0;
        res.cb = 8'd128;
        res.cr = 8'd128;
        res.last = 1'b0;
        row_end = column_pos >= w - 1;
        frame_end = row_end && row_pos >= h - 1;
        if (row_pos % 2 == 0)
        begin
            if (column_pos % 2 == 0)
            begin
                pair_first = px;
            end
            else
            begin
                ra = (int'(pair_first.red) + int'(px.red)) / 2;
                ga = (int'(pair_first.green) + int'(px.green)) / 2;
                ba = (int'(pair_first.blue) + int'(px.blue)) / 2;
                res.cb = chroma_from(-38 * ra - 74 * ga + 112 * ba);
                res.cr = chroma_from(112 * ra - 94 * ga - 18 * ba);
                res.chroma = 1'b1;
            end
        end
        if (frame_end)
        begin
            res.last = 1'b1;
            column_pos = 0;
            row_pos = 0;
        end
        else if (row_end)
        begin
            column_pos = 0;
            row_pos = row_pos + 1;
        end
        else
        begin
            column_pos = column_pos + 1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        yuv_sample_t want;
        yuv_sample_t got;
        if (!rst_n)
        begin
            width_reg = rgbyuv_pkg::FRAME_WIDTH_RST;
            height_reg = rgbyuv_pkg::FRAME_HEIGHT_RST;
            column_pos = 0;
            row_pos = 0;
            pair_first = '0;
            expected_yuv.delete();
        end
        else
        begin
            // retire the oldest expectation before queuing the new pixel
            if (result_valid && !result_stall)
            begin
                got = '{luma, chroma_valid, cb_value, cr_value, frame_last};
                if (expected_yuv.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result luma %0d cv %0d cb %0d cr %0d last %0d",
                                 $realtime, got.luma, got.chroma, got.cb, got.cr, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_yuv.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: result %0d expected luma %0d cv %0d cb %0d cr %0d ",
                                      "last %0d, got luma %0d cv %0d cb %0d cr %0d last %0d"},
                                     $realtime, results_checked, want.luma, want.chroma,
                                     want.cb, want.cr, want.last, got.luma, got.chroma,
                                     got.cb, got.cr, got.last);
                        mismatch_count++;
                    end
                end
                results_checked++;
                if (frame_last)
                    frames_closed++;
                if (chroma_valid)
                    chroma_pairs++;
            end
            if (cfg_write)
            begin
                if (cfg_index == rgbyuv_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == rgbyuv_pkg::REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
            end
            if (pixel_valid && !pixel_stall)
                expected_yuv.push_back(convert_pixel('{red, green, blue}));
        end
        pending_count = expected_yuv.size();
    end

endmodule

// File: dv/rgb_to_yuv420_converter_test.sv
module rgb_to_yuv420_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIZE    = 4096;
    localparam int PIXEL_TOTAL = 900;
    localparam int CALM_TAIL   = 150;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 300000;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [rgbyuv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rgbyuv_pkg::CFG_W-1:0]     cfg_data;
    logic                             pixel_valid;
    logic                             pixel_stall;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic                             result_valid;
    logic                             result_stall;
    logic [7:0]                       luma;
    logic                             chroma_valid;
    logic [7:0]                       cb_value;
    logic [7:0]                       cr_value;
    logic                             frame_last;

    int   mismatch_count;
    int   pending_count;
    int   results_checked;
    int   frames_closed;
    int   chroma_pairs;
    int   pixels_sent;
    int   reg_writes;
    int   hold_requests;
    int   sender_quiet;
    int   cycle_count;
    logic calm;

    rgb_to_yuv420_converter #(
        .MAX_DIMENSION(MAX_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .luma(luma),
        .chroma_valid(chroma_valid),
        .cb_value(cb_value),
        .cr_value(cr_value),
        .frame_last(frame_last)
    );

    yuv420_output_checker #(
        .MAX_DIMENSION(MAX_SIZE)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .luma(luma),
        .chroma_valid(chroma_valid),
        .cb_value(cb_value),
        .cr_value(cr_value),
        .frame_last(frame_last),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count),
        .results_checked(results_checked),
        .frames_closed(frames_closed),
        .chroma_pairs(chroma_pairs)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stall bursts, quiet stretches, and a long hold on request
    initial
    begin
        int burst_left;
        int quiet_left;
        int hold_left;
        int holds_done;
        burst_left = 0;
        quiet_left = 0;
        hold_left = 0;
        holds_done = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (calm)
            begin
                result_stall <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                result_stall <= 1'b1;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                result_stall <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 18) - 1;
                quiet_left = $urandom_range(0, 60);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    function automatic rgbyuv_pkg::pixel_t random_pixel();
        rgbyuv_pkg::pixel_t px;
        px.red = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue = 8'($urandom_range(0, 255));
        // push channels to the rails now and then
        if ($urandom_range(0, 7) == 0)
            px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return px;
    endfunction

    function automatic logic [rgbyuv_pkg::CFG_W-1:0] edge_size();
        case ($urandom_range(0, 5))
            0: return 13'd2;
            1: return 13'd4096;
            2: return 13'd0;
            3: return 13'd1;
            4: return 13'd4097;
            default: return 13'd8191;
        endcase
    endfunction

    task automatic send_pixel(input rgbyuv_pkg::pixel_t px);
        int gap;
        if (!calm)
        begin
            if (sender_quiet > 0)
            begin
                sender_quiet--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 18);
                @(negedge clk);
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                sender_quiet = $urandom_range(0, 60);
            end
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        red <= px.red;
        green <= px.green;
        blue <= px.blue;
        do
            @(posedge clk);
        while (pixel_stall);
        pixels_sent++;
    endtask

    task automatic pause_until_empty();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rgbyuv_pkg::CFG_IDX_W-1:0] index,
                             input logic [rgbyuv_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_frame(input logic [rgbyuv_pkg::CFG_W-1:0] width,
                             input logic [rgbyuv_pkg::CFG_W-1:0] height);
        pause_until_empty();
        write_reg(rgbyuv_pkg::REG_FRAME_WIDTH, width);
        write_reg(rgbyuv_pkg::REG_FRAME_HEIGHT, height);
    endtask

    initial
    begin
        int phase;
        int count;
        int pick;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = rgbyuv_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        pixel_valid = 1'b0;
        red = '0;
        green = '0;
        blue = '0;
        calm = 1'b0;
        pixels_sent = 0;
        reg_writes = 0;
        hold_requests = 0;
        sender_quiet = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame, rail colors and primaries
        set_frame(13'd2, 13'd2);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFF0000);
        send_pixel(24'hFF0000);
        send_pixel(24'h00FF00);
        send_pixel(24'h0000FF);
        send_pixel(24'h0000FF);
        send_pixel(24'h0000FF);
        send_pixel(24'hFFFF00);
        send_pixel(24'h00FFFF);
        // odd width rounds down, height below range clamps up
        set_frame(13'd3, 13'd1);
        send_pixel(24'h00FF00);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);
        send_pixel(24'h808080);
        // width above range clamps to the maximum, zero height clamps up
        set_frame(13'd8191, 13'd0);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);
        send_pixel(24'h0000FF);
        send_pixel(24'hFFFF00);
        // shrink the width mid row: column already past the new end
        set_frame(13'd4, 13'd4);
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);
        send_pixel(24'h7F7F7F);
        send_pixel(24'h010101);
        send_pixel(24'hFE80FE);

        phase = 0;
        while (pixels_sent < PIXEL_TOTAL)
        begin
            count = $urandom_range(8, 60);
            if (count > PIXEL_TOTAL - pixels_sent)
                count = PIXEL_TOTAL - pixels_sent;
            if (pixels_sent >= PIXEL_TOTAL - CALM_TAIL)
                calm = 1'b1;
            // keep the tail free of pauses
            if (!calm)
            begin
                pick = $urandom_range(0, 11);
                if (pick == 0)
                    set_frame(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
                else if (pick == 1)
                    set_frame(edge_size(), edge_size());
                else if (pick == 2)
                    pause_until_empty();
                else
                    set_frame(13'($urandom_range(1, 20)), 13'($urandom_range(1, 8)));
            end
            if (phase == 4)
            begin
                // back up the block: hold results while pixels keep coming
                calm = 1'b1;
                hold_requests++;
                repeat (40) send_pixel(random_pixel());
                calm = 1'b0;
            end
            repeat (count) send_pixel(random_pixel());
            phase++;
        end

        pause_until_empty();
        repeat (10) @(posedge clk);
        $display("%0d pixels in %0d stimulus blocks (%0d register writes), %0d results checked,",
                 pixels_sent, phase + 4, reg_writes, results_checked);
        $display("%0d chroma pairs and %0d frame ends seen in %0d cycles",
                 chroma_pairs, frames_closed, cycle_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hdl/rgbyuv_pkg.sv
hdl/rgbyuv_raster.sv
hdl/rgbyuv_color.sv
hdl/rgb_to_yuv420_converter.sv
dv/yuv420_output_checker.sv
dv/rgb_to_yuv420_converter_test.sv
